// ===== hdl/diff_drive_kinematics_rpm_limit_unit_macros.svh =====
// Assertion macros for the differential drive kinematics unit.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef DIFF_DRIVE_KINEMATICS_RPM_LIMIT_UNIT_MACROS_SVH
`define DIFF_DRIVE_KINEMATICS_RPM_LIMIT_UNIT_MACROS_SVH

// Same-cycle implication.
`define DDK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DDK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ddk_pkg.sv =====
// ----------------------------------------------------------------------------
// ddk_pkg
// Shared constants and helpers of the differential drive kinematics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ddk_pkg;

  localparam int unsigned CFG_W  = 31;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_TRACK   = 2'd0;
  localparam logic [IDX_W-1:0] REG_RADIUS  = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_RPM = 2'd2;

  localparam logic [CFG_W-1:0] TRACK_RST   = 31'd32768;
  localparam logic [CFG_W-1:0] RADIUS_RST  = 31'd3277;
  localparam logic [CFG_W-1:0] MAX_RPM_RST = 31'd19660800;

  // pi in Q60, split in two 31-bit halves for the radius product
  localparam logic [63:0]      PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [CFG_W-1:0] PI_HI  = PI_Q60[61:31];
  localparam logic [CFG_W-1:0] PI_LO  = PI_Q60[30:0];

  localparam int unsigned PROD_W   = 62;   // 31 x 31 partial product
  localparam int unsigned PSUM_W   = 93;   // pi * radius, full width
  localparam int unsigned D_SHIFT  = 40;
  localparam int unsigned DEN_W    = 53;   // pi*radius in Q(F+20)
  localparam int unsigned NUM_W    = 64;   // signed numerator
  localparam int unsigned ABS_W    = 63;
  localparam int unsigned T15_W    = 67;   // |n| * 15
  localparam int unsigned RPM_SH   = 20;
  localparam int unsigned DVD1_W   = T15_W + RPM_SH;
  localparam int unsigned Q1_W     = 66;
  localparam int unsigned MAG_W    = 59;
  localparam int unsigned K_W      = 64;
  localparam int unsigned TEN_W    = 63;   // magnitude * 10
  localparam int unsigned QS_W     = 31;

  localparam logic [MAG_W-1:0] MAG_CAP  = {MAG_W{1'b1}};
  localparam logic [MAG_W-1:0] NEG_LIM  = 59'h0_8000_0000;
  localparam logic [MAG_W-1:0] POS_LIM  = 59'h0_7FFF_FFFF;

  // Signed saturation of a magnitude and its sign to 32 bits
  function automatic logic [DATA_W-1:0] pack_out(input logic neg,
                                                 input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] mm;
    mm = mag;
    if (neg) begin
      if (mm > NEG_LIM) mm = NEG_LIM;
      mm = {MAG_W{1'b0}} - mm;
    end else begin
      if (mm > POS_LIM) mm = POS_LIM;
    end
    return mm[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ddk_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// ddk_sqrt_pipe
// Pipelined integer square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ddk_sqrt_pipe #(
  parameter int unsigned R_W  = 32,
  parameter int unsigned SB_W = 118
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             vld_i,
  input  wire logic [2*R_W-1:0] x_i,
  input  wire logic [SB_W-1:0]  sb_i,
  output logic                  vld_o,
  output logic [R_W-1:0]        root_o,
  output logic [SB_W-1:0]       sb_o
);

  localparam int unsigned X_W  = 2 * R_W;
  localparam int unsigned RM_W = R_W + 2;
  localparam int unsigned DF_W = RM_W + 3;

  logic [R_W-1:0]  vld_q;
  logic [X_W-1:0]  work_q [R_W];
  logic [R_W-1:0]  root_q [R_W];
  logic [RM_W-1:0] rem_q  [R_W];
  logic [SB_W-1:0] sb_q   [R_W];

  for (genvar s = 0; s < R_W; s++) begin : g_stage
    logic            src_vld;
    logic [X_W-1:0]  src_work;
    logic [R_W-1:0]  src_root;
    logic [RM_W-1:0] src_rem;
    logic [SB_W-1:0] src_sb;
    logic [RM_W+1:0] sh;
    logic [DF_W-1:0] diff;
    logic            ge;

    if (s == 0) begin : g_first
      assign src_vld  = vld_i;
      assign src_work = x_i;
      assign src_root = '0;
      assign src_rem  = '0;
      assign src_sb   = sb_i;
    end else begin : g_next
      assign src_vld  = vld_q[s-1];
      assign src_work = work_q[s-1];
      assign src_root = root_q[s-1];
      assign src_rem  = rem_q[s-1];
      assign src_sb   = sb_q[s-1];
    end

    // bring down two radicand bits, try root*4+1
    assign sh   = {src_rem, src_work[X_W-1 -: 2]};
    assign diff = {1'b0, sh} - DF_W'({src_root, 2'b01});
    assign ge   = ~diff[DF_W-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[RM_W-1:0] : sh[RM_W-1:0];
        root_q[s] <= {src_root[R_W-2:0], ge};
        work_q[s] <= {src_work[X_W-3:0], 2'b00};
        sb_q[s]   <= src_sb;
      end
    end
  end

  assign vld_o  = vld_q[R_W-1];
  assign root_o = root_q[R_W-1];
  assign sb_o   = sb_q[R_W-1];

endmodule

`default_nettype wire

// ===== hdl/ddk_div_pipe.sv =====
// ----------------------------------------------------------------------------
// ddk_div_pipe
// Pipelined restoring divider, one quotient bit per stage, shared divisor
// across lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module ddk_div_pipe #(
  parameter int unsigned DVD_W = 87,
  parameter int unsigned DEN_W = 53,
  parameter int unsigned Q_W   = 66,
  parameter int unsigned LANES = 2,
  parameter int unsigned SB_W  = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         vld_i,
  input  wire logic [DEN_W-1:0]             den_i,
  input  wire logic [LANES-1:0][DVD_W-1:0]  dvd_i,
  input  wire logic [SB_W-1:0]              sb_i,
  output logic                              vld_o,
  output logic [LANES-1:0][Q_W-1:0]         quo_o,
  output logic [SB_W-1:0]                   sb_o
);

  logic [Q_W-1:0]                vld_q;
  logic [LANES-1:0][DEN_W-1:0]   rem_q  [Q_W];
  logic [LANES-1:0][Q_W-1:0]     work_q [Q_W];
  logic [DEN_W-1:0]              den_q  [Q_W];
  logic [SB_W-1:0]               sb_q   [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic                        src_vld;
    logic [LANES-1:0][DEN_W-1:0] src_rem;
    logic [LANES-1:0][Q_W-1:0]   src_work;
    logic [DEN_W-1:0]            src_den;
    logic [SB_W-1:0]             src_sb;
    logic [LANES-1:0][DEN_W-1:0] rem_d;
    logic [LANES-1:0][Q_W-1:0]   work_d;

    if (s == 0) begin : g_first
      // upper dividend bits are known to stay below the divisor
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          src_rem[l]  = DEN_W'(dvd_i[l][DVD_W-1:Q_W]);
          src_work[l] = dvd_i[l][Q_W-1:0];
        end
      end
      assign src_vld = vld_i;
      assign src_den = den_i;
      assign src_sb  = sb_i;
    end else begin : g_next
      assign src_vld  = vld_q[s-1];
      assign src_rem  = rem_q[s-1];
      assign src_work = work_q[s-1];
      assign src_den  = den_q[s-1];
      assign src_sb   = sb_q[s-1];
    end

    always_comb begin
      logic [DEN_W:0]   sh;
      logic [DEN_W+1:0] diff;
      for (int l = 0; l < LANES; l++) begin
        sh   = {src_rem[l], src_work[l][Q_W-1]};
        diff = {1'b0, sh} - {2'b00, src_den};
        if (!diff[DEN_W+1]) begin
          rem_d[l]  = diff[DEN_W-1:0];
          work_d[l] = {src_work[l][Q_W-2:0], 1'b1};
        end else begin
          rem_d[l]  = sh[DEN_W-1:0];
          work_d[l] = {src_work[l][Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        work_q[s] <= work_d;
        den_q[s]  <= src_den;
        sb_q[s]   <= src_sb;
      end
    end
  end

  assign vld_o = vld_q[Q_W-1];
  assign quo_o = work_q[Q_W-1];
  assign sb_o  = sb_q[Q_W-1];

endmodule

`default_nettype wire

// ===== hdl/diff_drive_kinematics_rpm_limit_unit.sv =====
// ----------------------------------------------------------------------------
// diff_drive_kinematics_rpm_limit_unit
// Body velocity command to left/right wheel RPM with a proportional limiter.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (vel_x, vel_y, turn_rate) enter on a valid/ready channel; one
//   response (left_rpm, right_rpm, scaled) leaves per request, in order, on a
//   second valid/ready channel. Geometry and the RPM limit are written through
//   cfg_we_i / cfg_idx_i / cfg_data_i while no request is in flight.
//   The pipeline has 203 register stages. A new request is taken every cycle
//   unless a held response freezes the pipeline. The depth is
//   dominated by the bit-serial stages of the square root (32), the RPM
//   divider (66), the limit factor divider (64) and the scaling divider (31).
//   Reset clears every stage valid bit and loads the default geometry.
//   When the receiver holds out_ready_i low with a response pending, the
//   whole pipeline freezes and in_ready_o drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_kinematics_rpm_limit_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ddk_pkg::IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ddk_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [ddk_pkg::DATA_W-1:0] vel_x_i,
  input  wire logic signed [ddk_pkg::DATA_W-1:0] vel_y_i,
  input  wire logic signed [ddk_pkg::DATA_W-1:0] turn_rate_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [ddk_pkg::DATA_W-1:0] left_rpm_o,
  output logic signed [ddk_pkg::DATA_W-1:0] right_rpm_o,
  output logic                              scaled_o
);

  import ddk_pkg::*;

  localparam int unsigned SQ_SB_W = 1 + NUM_W + DEN_W;
  localparam int unsigned LM_SB_W = 2 * MAG_W + 3;

  // Configuration
  logic [CFG_W-1:0] track_q, radius_q, max_rpm_q;
  logic [CFG_W-1:0] rad, lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q   <= TRACK_RST;
      radius_q  <= RADIUS_RST;
      max_rpm_q <= MAX_RPM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRACK:   track_q   <= cfg_data_i;
        REG_RADIUS:  radius_q  <= cfg_data_i;
        REG_MAX_RPM: max_rpm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rad = (radius_q == '0) ? CFG_W'(1) : radius_q;
  assign lim = (max_rpm_q == '0) ? CFG_W'(1) : max_rpm_q;

  // Global advance: everything moves unless a response is held
  logic en;
  logic out_vld_q;
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: magnitudes
  logic                     s1_vld_q, s1_yneg_q;
  logic [DATA_W-1:0]        s1_ax_q, s1_ay_q;
  logic signed [DATA_W-1:0] s1_w_q;

  // Stage 2: products
  logic                     s2_vld_q, s2_yneg_q;
  logic [2*DATA_W-1:0]      s2_sqx_q, s2_sqy_q, s2_sqx_d, s2_sqy_d;
  logic signed [NUM_W-1:0]  s2_tw_q, s2_tw_d;
  logic [PROD_W-1:0]        s2_ph_q, s2_pl_q, s2_ph_d, s2_pl_d;

  // Stage 3: radicand and divisor
  logic                     s3_vld_q, s3_yneg_q;
  logic [2*DATA_W-1:0]      s3_x_q;
  logic signed [NUM_W-1:0]  s3_tw_q;
  logic [DEN_W-1:0]         s3_d_q;
  logic [PSUM_W-1:0]        s3_psum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  assign s2_sqx_d = s1_ax_q * s1_ax_q;
  assign s2_sqy_d = s1_ay_q * s1_ay_q;
  assign s2_tw_d  = $signed({1'b0, track_q}) * s1_w_q;
  assign s2_ph_d  = PI_HI * rad;
  assign s2_pl_d  = PI_LO * rad;
  assign s3_psum  = {s2_ph_q, 31'b0} + PSUM_W'(s2_pl_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ax_q   <= vel_x_i[DATA_W-1] ? DATA_W'(-vel_x_i) : vel_x_i;
      s1_ay_q   <= vel_y_i[DATA_W-1] ? DATA_W'(-vel_y_i) : vel_y_i;
      s1_w_q    <= turn_rate_i;
      s1_yneg_q <= vel_y_i[DATA_W-1];
      s2_sqx_q  <= s2_sqx_d;
      s2_sqy_q  <= s2_sqy_d;
      s2_tw_q   <= s2_tw_d;
      s2_ph_q   <= s2_ph_d;
      s2_pl_q   <= s2_pl_d;
      s2_yneg_q <= s1_yneg_q;
      s3_x_q    <= s2_sqx_q + s2_sqy_q;
      s3_tw_q   <= s2_tw_q;
      s3_d_q    <= s3_psum[D_SHIFT +: DEN_W];
      s3_yneg_q <= s2_yneg_q;
    end
  end

  // Square root
  logic               sq_vld;
  logic [DATA_W-1:0]  sq_root;
  logic [SQ_SB_W-1:0] sq_sb;

  ddk_sqrt_pipe #(
    .R_W  (DATA_W),
    .SB_W (SQ_SB_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s3_vld_q),
    .x_i    (s3_x_q),
    .sb_i   ({s3_yneg_q, s3_tw_q, s3_d_q}),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .sb_o   (sq_sb)
  );

  // Stage 4: wheel numerators
  logic                    sq_yneg;
  logic signed [NUM_W-1:0] sq_tw, sv, svs;
  logic [DEN_W-1:0]        sq_d;
  logic                    s4_vld_q;
  logic signed [NUM_W-1:0] s4_nl_q, s4_nr_q;
  logic [DEN_W-1:0]        s4_d_q;

  assign {sq_yneg, sq_tw, sq_d} = sq_sb;
  assign sv  = $signed(NUM_W'(sq_root) << (FRAC_BITS + 1));
  assign svs = sq_yneg ? -sv : sv;

  // Stage 5: magnitudes; stage 6: times 15
  logic                    s5_vld_q, s6_vld_q;
  logic [1:0]              s5_neg_q, s6_neg_q;
  logic [ABS_W-1:0]        s5_al_q, s5_ar_q;
  logic [T15_W-1:0]        s6_tl_q, s6_tr_q;
  logic [DEN_W-1:0]        s5_d_q, s6_d_q;
  logic [NUM_W-1:0]        nl_abs, nr_abs;

  assign nl_abs = s4_nl_q[NUM_W-1] ? NUM_W'(-s4_nl_q) : NUM_W'(s4_nl_q);
  assign nr_abs = s4_nr_q[NUM_W-1] ? NUM_W'(-s4_nr_q) : NUM_W'(s4_nr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= sq_vld;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_nl_q  <= svs - sq_tw;
      s4_nr_q  <= svs + sq_tw;
      s4_d_q   <= sq_d;
      s5_al_q  <= nl_abs[ABS_W-1:0];
      s5_ar_q  <= nr_abs[ABS_W-1:0];
      s5_neg_q <= {s4_nl_q[NUM_W-1], s4_nr_q[NUM_W-1]};
      s5_d_q   <= s4_d_q;
      s6_tl_q  <= {s5_al_q, 4'b0000} - T15_W'(s5_al_q);
      s6_tr_q  <= {s5_ar_q, 4'b0000} - T15_W'(s5_ar_q);
      s6_neg_q <= s5_neg_q;
      s6_d_q   <= s5_d_q;
    end
  end

  // RPM magnitude divider: |n| * 15 * 2^20 / D
  logic                       d1_vld;
  logic [1:0][Q1_W-1:0]       d1_quo;
  logic [1:0]                 d1_neg;

  ddk_div_pipe #(
    .DVD_W (DVD1_W),
    .DEN_W (DEN_W),
    .Q_W   (Q1_W),
    .LANES (2),
    .SB_W  (2)
  ) u_div_rpm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s6_vld_q),
    .den_i  (s6_d_q),
    .dvd_i  ({{s6_tl_q, {RPM_SH{1'b0}}}, {s6_tr_q, {RPM_SH{1'b0}}}}),
    .sb_i   (s6_neg_q),
    .vld_o  (d1_vld),
    .quo_o  (d1_quo),
    .sb_o   (d1_neg)
  );

  // Stage 7: saturate and take the larger; stage 8: limit test and k numerator
  logic               s7_vld_q, s8_vld_q;
  logic [1:0]         s7_neg_q, s8_neg_q;
  logic [MAG_W-1:0]   s7_ml_q, s7_mr_q, s7_m_q, s8_ml_q, s8_mr_q;
  logic [MAG_W-1:0]   ml_sat, mr_sat;
  logic               s8_sc_q;
  logic [K_W-1:0]     s8_kn_q;

  assign ml_sat = (d1_quo[1] > Q1_W'(MAG_CAP)) ? MAG_CAP : d1_quo[1][MAG_W-1:0];
  assign mr_sat = (d1_quo[0] > Q1_W'(MAG_CAP)) ? MAG_CAP : d1_quo[0][MAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
    end else if (en) begin
      s7_vld_q <= d1_vld;
      s8_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_ml_q  <= ml_sat;
      s7_mr_q  <= mr_sat;
      s7_m_q   <= (ml_sat >= mr_sat) ? ml_sat : mr_sat;
      s7_neg_q <= d1_neg;
      s8_ml_q  <= s7_ml_q;
      s8_mr_q  <= s7_mr_q;
      s8_neg_q <= s7_neg_q;
      s8_sc_q  <= s7_m_q > MAG_W'(lim);
      // ceil(10*m / lim) numerator
      s8_kn_q  <= K_W'({s7_m_q, 3'b000}) + K_W'({s7_m_q, 1'b0}) + K_W'(lim) - K_W'(1);
    end
  end

  // Limit factor divider
  logic               dk_vld;
  logic [0:0][K_W-1:0] dk_quo;
  logic [LM_SB_W-1:0] dk_sb;

  ddk_div_pipe #(
    .DVD_W (K_W + 1),
    .DEN_W (CFG_W),
    .Q_W   (K_W),
    .LANES (1),
    .SB_W  (LM_SB_W)
  ) u_div_k (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s8_vld_q),
    .den_i  (lim),
    .dvd_i  ({1'b0, s8_kn_q}),
    .sb_i   ({s8_ml_q, s8_mr_q, s8_neg_q, s8_sc_q}),
    .vld_o  (dk_vld),
    .quo_o  (dk_quo),
    .sb_o   (dk_sb)
  );

  // Stage 9: 10 * magnitude for the scaling divide
  logic               s9_vld_q;
  logic [K_W-1:0]     s9_k_q;
  logic [TEN_W-1:0]   s9_tl_q, s9_tr_q;
  logic [LM_SB_W-1:0] s9_sb_q;
  logic [MAG_W-1:0]   dk_ml, dk_mr;

  assign dk_ml = dk_sb[LM_SB_W-1 -: MAG_W];
  assign dk_mr = dk_sb[3 +: MAG_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_vld_q <= 1'b0;
    end else if (en) begin
      s9_vld_q <= dk_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_k_q  <= dk_quo[0];
      s9_tl_q <= TEN_W'({dk_ml, 3'b000}) + TEN_W'({dk_ml, 1'b0});
      s9_tr_q <= TEN_W'({dk_mr, 3'b000}) + TEN_W'({dk_mr, 1'b0});
      s9_sb_q <= dk_sb;
    end
  end

  // Scaling divider: 10 * magnitude / k
  logic               ds_vld;
  logic [1:0][QS_W-1:0] ds_quo;
  logic [LM_SB_W-1:0] ds_sb;

  ddk_div_pipe #(
    .DVD_W (TEN_W),
    .DEN_W (K_W),
    .Q_W   (QS_W),
    .LANES (2),
    .SB_W  (LM_SB_W)
  ) u_div_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s9_vld_q),
    .den_i  (s9_k_q),
    .dvd_i  ({s9_tl_q, s9_tr_q}),
    .sb_i   (s9_sb_q),
    .vld_o  (ds_vld),
    .quo_o  (ds_quo),
    .sb_o   (ds_sb)
  );

  // Output register
  logic [MAG_W-1:0]  fin_ml, fin_mr, raw_ml, raw_mr;
  logic [1:0]        fin_neg;
  logic              fin_sc;
  logic [DATA_W-1:0] left_q, right_q;
  logic              sc_q;

  assign {raw_ml, raw_mr, fin_neg, fin_sc} = ds_sb;
  assign fin_ml = fin_sc ? MAG_W'(ds_quo[1]) : raw_ml;
  assign fin_mr = fin_sc ? MAG_W'(ds_quo[0]) : raw_mr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= ds_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      left_q  <= pack_out(fin_neg[1], fin_ml);
      right_q <= pack_out(fin_neg[0], fin_mr);
      sc_q    <= fin_sc;
    end
  end

  assign out_valid_o = out_vld_q;
  assign left_rpm_o  = $signed(left_q);
  assign right_rpm_o = $signed(right_q);
  assign scaled_o    = sc_q;

endmodule

`default_nettype wire

// ===== hdl/ddk_checker.sv =====
// ----------------------------------------------------------------------------
// ddk_checker
// Port-level checks of the kinematics unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "diff_drive_kinematics_rpm_limit_unit_macros.svh"

module ddk_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] left_rpm_o,
  input wire logic [31:0] right_rpm_o,
  input wire logic        scaled_o
);

  `DDK_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(left_rpm_o) && $stable(right_rpm_o) && $stable(scaled_o), "pending response changed")
  `DDK_ASSERT_IMP(a_ready_law, 1'b1, in_ready_o == (!out_valid_o || out_ready_i), "request stalled without a held response")
  `DDK_ASSERT_IMP(a_rise_adv, $rose(out_valid_o), $past(in_ready_o), "response appeared while frozen")

endmodule

bind diff_drive_kinematics_rpm_limit_unit ddk_checker u_ddk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .left_rpm_o  (left_rpm_o),
  .right_rpm_o (right_rpm_o),
  .scaled_o    (scaled_o)
);

`default_nettype wire

// ===== tb/tb_diff_drive_kinematics_rpm_limit_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_diff_drive_kinematics_rpm_limit_unit
// Drives body velocity requests through the kinematics unit under several
// geometry and RPM limit settings. A local model predicts each wheel RPM pair
// and the scaled flag. Every response is checked in order against it, with
// random stalls on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_diff_drive_kinematics_rpm_limit_unit;
  import ddk_pkg::*;

  localparam int unsigned FRAC    = 16;
  localparam int unsigned LATENCY = 203;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam logic [63:0] RPM_CAP = 64'h07FF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
    logic                     scaled;
  } wheel_rpm_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [IDX_W-1:0]         cfg_idx_i;
  logic [CFG_W-1:0]         cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] vel_x_i;
  logic signed [DATA_W-1:0] vel_y_i;
  logic signed [DATA_W-1:0] turn_rate_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] left_rpm_o;
  logic signed [DATA_W-1:0] right_rpm_o;
  logic                     scaled_o;

  diff_drive_kinematics_rpm_limit_unit #(.FRAC_BITS(FRAC)) dut (.*);

  logic [CFG_W-1:0] track_q, radius_q, max_rpm_q;
  wheel_rpm_t       rpm_q[$];
  int               errors;
  int               idle_cnt;
  bit               calm;       // no random idling on either side while set
  int               hold_req;   // receiver hold-off length, taken by its process

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag64(input longint a);
    return (a < 0) ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic [63:0] wheel_mag(input longint n, input logic [63:0] d);
    logic [127:0] q;
    q = (128'(mag64(n)) * 128'(64'd15 << 20)) / 128'(d);
    return (q > 128'(RPM_CAP)) ? RPM_CAP : q[63:0];
  endfunction

  function automatic logic [DATA_W-1:0] saturate(input bit neg, input logic [63:0] mag);
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return DATA_W'(64'd0 - mag);
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[DATA_W-1:0];
  endfunction

  function automatic wheel_rpm_t wheel_speeds(input logic signed [31:0] x,
                                              input logic signed [31:0] y,
                                              input logic signed [31:0] w);
    wheel_rpm_t  r;
    logic [63:0] ax, ay, v, rad, lim, d, ml, mr, m, k;
    logic [127:0] pr;
    longint      sv, tw, nl, nr, trk;
    ax = mag64(longint'(x));
    ay = mag64(longint'(y));
    v = isqrt(ax * ax + ay * ay);
    sv = longint'(v << (FRAC + 1));
    if (y < 0) sv = -sv;
    trk = longint'({33'd0, track_q});
    tw = trk * longint'(w);
    nl = sv - tw;
    nr = sv + tw;
    rad = (radius_q == 0) ? 64'd1 : 64'(radius_q);
    lim = (max_rpm_q == 0) ? 64'd1 : 64'(max_rpm_q);
    pr = 128'(PI_Q60) * 128'(rad);
    d = 64'(pr >> 40);
    ml = wheel_mag(nl, d);
    mr = wheel_mag(nr, d);
    m = (ml >= mr) ? ml : mr;
    r.scaled = 1'b0;
    if (m > lim) begin
      k = (64'd10 * m + lim - 64'd1) / lim;
      ml = ml * 64'd10 / k;
      mr = mr * 64'd10 / k;
      r.scaled = 1'b1;
    end
    r.left = saturate(nl < 0, ml);
    r.right = saturate(nr < 0, mr);
    return r;
  endfunction

  // Receiver: random stalls, calm stretches and a counted hold-off.
  initial begin
    int hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 34);
      end
    end
  end

  // Response checker.
  always @(posedge clk_i) begin
    wheel_rpm_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rpm_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response: left %0d right %0d scaled %0b",
                                   left_rpm_o, right_rpm_o, scaled_o);
      end else begin
        exp_r = rpm_q.pop_front();
        if (left_rpm_o !== exp_r.left || right_rpm_o !== exp_r.right ||
            scaled_o !== exp_r.scaled) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: left %0d/%0d right %0d/%0d scaled %0b/%0b (exp/act)",
                     exp_r.left, left_rpm_o, exp_r.right, right_rpm_o,
                     exp_r.scaled, scaled_o);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_LIMIT) begin
      $display("tb_diff_drive_kinematics_rpm_limit_unit: done, errors");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  task automatic send_cmd(input logic signed [31:0] x, input logic signed [31:0] y,
                          input logic signed [31:0] w);
    vel_x_i <= x;
    vel_y_i <= y;
    turn_rate_i <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    rpm_q.push_back(wheel_speeds(x, y, w));
    // idle each following cycle with the same odds
    while (!calm && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Lower valid and wait until every response is back.
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rpm_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TRACK:   track_q = val;
      REG_RADIUS:  radius_q = val;
      REG_MAX_RPM: max_rpm_q = val;
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] trk, input logic [CFG_W-1:0] rad,
                              input logic [CFG_W-1:0] lim);
    write_reg(REG_TRACK, trk);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_MAX_RPM, lim);
  endtask

  function automatic logic signed [31:0] rand_speed();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $signed(32'($urandom_range(0, 2 << FRAC))) - (1 << FRAC);
      2:       return $signed(32'($urandom_range(0, 32 << FRAC))) - (16 << FRAC);
      default: return $signed(32'($urandom_range(0, 1 << 24))) - (1 << 23);
    endcase
  endfunction

  task automatic test_directed;
    logic signed [31:0] ext[6];
    ext = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 1, 32'sh0001_0000};
    for (int i = 0; i < 6; i++) send_cmd(ext[i], ext[(i + 2) % 6], ext[(i + 4) % 6]);
    send_cmd(0, 0, 0);
    send_cmd(32'sh0001_0000, 0, 0);          // forward, x only
    send_cmd(0, -32'sh0001_0000, 0);         // reverse sets negative speed
    send_cmd(0, 0, 32'sh0001_0000);          // spin in place
    send_cmd(0, 32'sh0000_8000, 32'sh0001_0000); // forward with a turn
    send_cmd(32'sh0004_0000, 32'sh0004_0000, 32'sh0010_0000); // hits the limiter
    send_cmd(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_cmd(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_cmd(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    drain();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(3) == 0);
      send_cmd(rand_speed(), rand_speed(), rand_speed());
    end
    calm = 1'b0;
    drain();
  endtask

  task automatic test_backpressure;
    calm = 1'b1;
    hold_req = 400;
    for (int i = 0; i < 300; i++) send_cmd(rand_speed(), rand_speed(), rand_speed());
    calm = 1'b0;
    drain();
  endtask

  task automatic test_geometry_sweep;
    set_geometry(31'd1, 31'd1, 31'd1);
    test_directed();
    test_random(60);
    set_geometry(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    test_directed();
    test_random(60);
    set_geometry(31'd0, 31'd0, 31'd0);    // zero radius and limit act as one
    test_random(40);
    set_geometry(31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF);
    test_random(60);
    for (int p = 0; p < 3; p++) begin
      set_geometry(31'($urandom_range(1 << 12, 1 << 18)), 31'($urandom_range(1 << 10, 1 << 16)),
                   31'($urandom_range(1 << 16, 1 << 28)));
      test_random(60);
    end
    set_geometry(31'($urandom), 31'($urandom), 31'($urandom));
    test_random(40);
  endtask

  initial begin
    clk_i = 1'b0;
    errors = 0;
    calm = 1'b0;
    hold_req = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_TRACK;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    vel_x_i = '0;
    vel_y_i = '0;
    turn_rate_i = '0;
    track_q = TRACK_RST;
    radius_q = RADIUS_RST;
    max_rpm_q = MAX_RPM_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(40);
    test_backpressure();
    test_geometry_sweep();

    if (errors == 0) begin
      $display("tb_diff_drive_kinematics_rpm_limit_unit: done, clean");
    end else begin
      $display("tb_diff_drive_kinematics_rpm_limit_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ddk_pkg.sv
hdl/ddk_sqrt_pipe.sv
hdl/ddk_div_pipe.sv
hdl/diff_drive_kinematics_rpm_limit_unit.sv
hdl/ddk_checker.sv
tb/tb_diff_drive_kinematics_rpm_limit_unit.sv
